@@ rtl/core/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and codes of the streaming Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   // One input beat: a character or a flush marker.
   typedef struct packed {
      logic       mode;
      logic [7:0] char_in;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic [2:0] status;
   } rsp_type;

   // Kind of a classified input beat.
   localparam logic [2:0] KIND_SYM   = 3'd0;
   localparam logic [2:0] KIND_PAD   = 3'd1;
   localparam logic [2:0] KIND_SPACE = 3'd2;
   localparam logic [2:0] KIND_BAD   = 3'd3;
   localparam logic [2:0] KIND_FLUSH = 3'd4;

   // Classified beat handed from the front end to the back end.
   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] sym;
   } cmd_type;

   // Result status codes.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_CHAR      = 3'd1;
   localparam logic [2:0] ST_SYM_AFTER_PAD = 3'd2;
   localparam logic [2:0] ST_INCOMPLETE    = 3'd3;
   localparam logic [2:0] ST_IN_ERROR      = 3'd4;

   // Widths of the two queues between the parts.
   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

@@ rtl/core/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder, one character or flush beat in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_data (mode, char_in) and raise push; the beat is
//   taken on a clock edge where push is high and full is low. mode = 1 is a
//   flush that checks the stream ended on a whole-byte boundary.
//   Result channel: while empty is low, rsp_data holds the oldest result
//   (byte_valid, data_byte, status); raising pop takes it.
//   Every input beat produces exactly one result beat, in order.
// Timing:
//   A result reaches the result ports through the two queues: the beat is
//   registered in the classified-command queue, is decoded as it leaves, and
//   is registered again in the result queue, from which it can be popped.
//   Throughput is one beat per cycle while the result queue is not full, set
//   by the combinational decode step in the back end.
// Reset:
//   Synchronous reset empties both queues and returns the decoder to no bits
//   pending. Only reset clears the sticky error state.
// Stall:
//   When pop stays low the result queue fills, the back end holds, the
//   command queue fills behind it and full rises after two more beats.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::req_type req_data,
   output logic              full,
   input  logic              pop,
   output b64d_pkg::rsp_type rsp_data,
   output logic              empty
);
   import b64d_pkg::*;

   cmd_type cmd_in_data;
   logic    cmd_push;
   logic    cmd_full;
   cmd_type cmd_out_data;
   logic    cmd_empty;
   logic    cmd_pop;
   rsp_type rsp_in_data;
   logic    rsp_push;
   logic    rsp_full;

   // Front end: classify incoming characters.
   b64d_front u_front (
      .req_data (req_data),
      .push     (push),
      .full     (full),
      .cmd_data (cmd_in_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full)
   );

   // Queue of classified beats between front and back.
   b64d_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .in_data  (cmd_in_data),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .out_data (cmd_out_data),
      .empty    (cmd_empty)
   );

   // Back end: decode state and result forming.
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_out_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_in_data),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   // Result queue toward the receiver.
   b64d_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .in_data  (rsp_in_data),
      .full     (rsp_full),
      .pop      (pop),
      .out_data (rsp_data),
      .empty    (empty)
   );

endmodule

@@ rtl/core/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Two-entry queue built from a head and a tail register, full throughput.
// ----------------------------------------------------------------------------
module b64d_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] in_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] out_data,
   output logic             empty
);

   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             head_valid_ff, head_valid_in;
   logic             tail_valid_ff, tail_valid_in;
   logic             do_push;
   logic             do_pop;

   assign full     = tail_valid_ff;
   assign empty    = !head_valid_ff;
   assign out_data = head_ff;
   assign do_push  = push && !tail_valid_ff;
   assign do_pop   = pop && head_valid_ff;

   // The head always holds the oldest beat; the tail only fills when the
   // head is occupied and not leaving in the same cycle.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (do_pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else if (do_push) begin
            head_in = in_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (do_push) begin
         if (head_valid_ff) begin
            tail_in       = in_data;
            tail_valid_in = 1'b1;
         end else begin
            head_in       = in_data;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   // The tail is never occupied while the head is empty.
   a_tail_needs_head: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("queue tail occupied with empty head");

   // A beat pushed into an occupied head without a pop lands in the tail.
   a_push_fills_tail: assert property (@(posedge clock) disable iff (reset)
      (do_push && head_valid_ff && !pop) |=> (tail_valid_ff && tail_ff == $past(in_data)))
      else $error("queue lost a pushed beat");

   // A pop with a waiting tail moves the tail beat to the head.
   a_pop_moves_tail: assert property (@(posedge clock) disable iff (reset)
      (do_pop && tail_valid_ff) |=> (head_valid_ff && head_ff == $past(tail_ff)))
      else $error("queue head not refilled from tail");

endmodule

@@ rtl/core/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Front end: classifies each input beat into symbol, pad, space, bad or flush.
// ----------------------------------------------------------------------------
module b64d_front (
   input  b64d_pkg::req_type req_data,
   input  logic              push,
   output logic              full,
   output b64d_pkg::cmd_type cmd_data,
   output logic              cmd_push,
   input  logic              cmd_full
);
   import b64d_pkg::*;

   // Map one ASCII character to its class and 6-bit symbol value.
   function automatic cmd_type classify(input logic [7:0] c);
      cmd_type    r;
      logic [7:0] v;
      r.kind = KIND_BAD;
      r.sym  = 6'd0;
      v      = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v      = c - 8'h41;
         r.kind = KIND_SYM;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v      = c - 8'h61 + 8'd26;
         r.kind = KIND_SYM;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v      = c - 8'h30 + 8'd52;
         r.kind = KIND_SYM;
      end else if (c == 8'h2B) begin
         v      = 8'd62;
         r.kind = KIND_SYM;
      end else if (c == 8'h2F) begin
         v      = 8'd63;
         r.kind = KIND_SYM;
      end else if (c == 8'h3D) begin
         r.kind = KIND_PAD;
      end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
         r.kind = KIND_SPACE;
      end
      r.sym = v[5:0];
      return r;
   endfunction

   // Flush beats bypass the character classifier.
   always_comb begin
      if (req_data.mode) begin
         cmd_data.kind = KIND_FLUSH;
         cmd_data.sym  = 6'd0;
      end else begin
         cmd_data = classify(req_data.char_in);
      end
   end

   assign cmd_push = push;
   assign full     = cmd_full;

endmodule

@@ rtl/core/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Back end: holds the decode phase and leftover bits and forms each result.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  b64d_pkg::cmd_type cmd_data,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output b64d_pkg::rsp_type rsp_data,
   output logic              rsp_push,
   input  logic              rsp_full
);
   import b64d_pkg::*;

   // Phase codes: how many bits are pending, or pad seen, or error.
   localparam logic [2:0] PH_EMPTY = 3'd0;
   localparam logic [2:0] PH_SIX   = 3'd1;
   localparam logic [2:0] PH_FOUR  = 3'd2;
   localparam logic [2:0] PH_TWO   = 3'd3;
   localparam logic [2:0] PH_PAD   = 3'd4;
   localparam logic [2:0] PH_ERR   = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  pending_ff, pending_in;
   logic [11:0] acc;
   logic        fire;

   assign fire     = !cmd_empty && !rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;
   assign acc      = {pending_ff, cmd_data.sym};

   // Decode step for the beat at the head of the command queue.
   always_comb begin
      phase_in            = phase_ff;
      pending_in          = pending_ff;
      rsp_data.byte_valid = 1'b0;
      rsp_data.data_byte  = 8'd0;
      rsp_data.status     = ST_OK;
      if (phase_ff >= PH_ERR) begin
         rsp_data.status = ST_IN_ERROR;
      end else begin
         case (cmd_data.kind)
            KIND_FLUSH: begin
               if (phase_ff == PH_SIX || phase_ff == PH_FOUR || phase_ff == PH_TWO) begin
                  rsp_data.status = ST_INCOMPLETE;
               end
            end
            KIND_PAD: begin
               phase_in   = PH_PAD;
               pending_in = 6'd0;
            end
            KIND_SPACE: begin
               phase_in = phase_ff;
            end
            KIND_SYM: begin
               case (phase_ff)
                  PH_EMPTY: begin
                     pending_in = cmd_data.sym;
                     phase_in   = PH_SIX;
                  end
                  PH_SIX: begin
                     rsp_data.byte_valid = 1'b1;
                     rsp_data.data_byte  = acc[11:4];
                     pending_in          = {2'b00, acc[3:0]};
                     phase_in            = PH_FOUR;
                  end
                  PH_FOUR: begin
                     rsp_data.byte_valid = 1'b1;
                     rsp_data.data_byte  = acc[9:2];
                     pending_in          = {4'b0000, acc[1:0]};
                     phase_in            = PH_TWO;
                  end
                  PH_TWO: begin
                     rsp_data.byte_valid = 1'b1;
                     rsp_data.data_byte  = acc[7:0];
                     pending_in          = 6'd0;
                     phase_in            = PH_EMPTY;
                  end
                  default: begin
                     phase_in        = PH_ERR;
                     rsp_data.status = ST_SYM_AFTER_PAD;
                  end
               endcase
            end
            default: begin
               phase_in        = PH_ERR;
               rsp_data.status = ST_BAD_CHAR;
            end
         endcase
      end
   end

   // State advances only when a beat moves from one queue to the other.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_EMPTY;
         pending_ff <= 6'd0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

   // Phases beyond the error code are never reached.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_ERR)
      else $error("decoder phase out of range");

   // A bad character or a symbol after pad leaves the decoder in error.
   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (fire && (rsp_data.status == ST_BAD_CHAR || rsp_data.status == ST_SYM_AFTER_PAD))
      |=> phase_ff == PH_ERR)
      else $error("error status without entering error phase");

   // Leftover bits never exceed what the current phase holds.
   a_pending_fits: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff != PH_FOUR) || (pending_ff[5:4] == 2'b00)) &&
      ((phase_ff != PH_TWO) || (pending_ff[5:2] == 4'b0000)))
      else $error("pending bits wider than phase allows");

endmodule

@@ dv/base64_stream_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the streaming Base64 decoder. Character and flush
// beats go in through the input queue with random gaps. A scoreboard class
// tracks the decoder's bit phase and leftover bits, predicts one result per
// accepted beat, and compares every popped result field by field. The error
// state is sticky until reset, so the run decodes a long well-formed stream
// first and ends with padding, one error and a tail of beats in the error
// state.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam logic MODE_CHAR  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   localparam int BODY_BEATS = 1500;
   localparam int TAIL_BEATS = 80;
   localparam int MAX_GAP    = 17;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 200;

   // The six whitespace characters that the decoder skips.
   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   // Decoder phase: how many bits wait for the next symbol.
   typedef enum logic [2:0] {
      HOLD_NONE = 3'd0,
      HOLD_SIX  = 3'd1,
      HOLD_FOUR = 3'd2,
      HOLD_TWO  = 3'd3,
      PAD_SEEN  = 3'd4,
      STUCK     = 3'd5
   } dec_phase_type;

   // Predicts decoded bytes and status codes, and checks popped results.
   class decode_scoreboard;
      dec_phase_type phase;
      logic [5:0]    leftover;
      rsp_type       awaited[$];
      int            failures;

      function new();
         phase    = HOLD_NONE;
         leftover = '0;
         failures = 0;
      endfunction

      // Sort a character into symbol, padding, whitespace or invalid.
      static function void classify_char(input logic [7:0] c, output logic [2:0] kind,
                                         output logic [5:0] sym);
         sym  = '0;
         kind = KIND_SYM;
         if (c >= "A" && c <= "Z") sym = 6'(c - "A");
         else if (c >= "a" && c <= "z") sym = 6'(c - "a" + 8'd26);
         else if (c >= "0" && c <= "9") sym = 6'(c - "0" + 8'd52);
         else if (c == "+") sym = 6'd62;
         else if (c == "/") sym = 6'd63;
         else if (c == "=") kind = KIND_PAD;
         else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) kind = KIND_SPACE;
         else kind = KIND_BAD;
      endfunction

      // Advance the predicted decoder by one accepted beat.
      function void note_beat(req_type beat);
         rsp_type     res;
         logic [2:0]  kind;
         logic [5:0]  sym;
         logic [11:0] acc;
         res        = '0;
         res.status = ST_OK;
         if (phase == STUCK) begin
            res.status = ST_IN_ERROR;
         end else if (beat.mode == MODE_FLUSH) begin
            if (phase inside {HOLD_SIX, HOLD_FOUR, HOLD_TWO}) res.status = ST_INCOMPLETE;
         end else begin
            classify_char(beat.char_in, kind, sym);
            acc = {leftover, sym};
            case (kind)
               KIND_BAD: begin
                  phase      = STUCK;
                  res.status = ST_BAD_CHAR;
               end
               KIND_PAD: begin
                  phase    = PAD_SEEN;
                  leftover = '0;
               end
               KIND_SPACE: ;
               default: begin
                  case (phase)
                     HOLD_NONE: begin
                        leftover = sym;
                        phase    = HOLD_SIX;
                     end
                     HOLD_SIX: begin
                        res.byte_valid = 1'b1;
                        res.data_byte  = acc[11:4];
                        leftover       = {2'b00, acc[3:0]};
                        phase          = HOLD_FOUR;
                     end
                     HOLD_FOUR: begin
                        res.byte_valid = 1'b1;
                        res.data_byte  = acc[9:2];
                        leftover       = {4'b0000, acc[1:0]};
                        phase          = HOLD_TWO;
                     end
                     HOLD_TWO: begin
                        res.byte_valid = 1'b1;
                        res.data_byte  = acc[7:0];
                        leftover       = '0;
                        phase          = HOLD_NONE;
                     end
                     default: begin
                        phase      = STUCK;
                        res.status = ST_SYM_AFTER_PAD;
                     end
                  endcase
               end
            endcase
         end
         awaited.push_back(res);
      endfunction

      // Compare a popped result with the oldest prediction.
      function void check_beat(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result beat with no prediction waiting: %p", got);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, actual %0d", want.byte_valid, got.byte_valid);
            failures++;
         end
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, got.data_byte);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    pop      = 1'b0;
   rsp_type rsp_data;
   logic    empty;

   decode_scoreboard sb = new();
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   base64_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .pop      (pop),
      .rsp_data (rsp_data),
      .empty    (empty)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap before a beat; a calm stretch has no idling at all.
   function automatic int draw_gap(bit calm);
      return calm ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   // Character of a 6-bit symbol value.
   function automatic logic [7:0] symbol_char(int unsigned v);
      if (v < 26) return 8'(v) + "A";
      if (v < 52) return 8'(v - 26) + "a";
      if (v < 62) return 8'(v - 52) + "0";
      return (v == 62) ? "+" : "/";
   endfunction

   // Offer one beat and wait until the decoder takes it.
   task automatic send_beat(logic mode, logic [7:0] ch);
      int gap;
      gap = draw_gap(tx_calm);
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= '{mode: mode, char_in: ch};
      do @(posedge clock); while (full);
      sb.note_beat('{mode: mode, char_in: ch});
   endtask

   task automatic send_char(logic [7:0] ch);
      send_beat(MODE_CHAR, ch);
   endtask

   // Flush beats carry a random character, which must be ignored.
   task automatic send_flush();
      send_beat(MODE_FLUSH, 8'($urandom));
   endtask

   // Stimulus, drain and final verdict.
   initial begin
      logic [7:0]  ch;
      logic [2:0]  kind;
      logic [5:0]  sym;
      int unsigned pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: flush in every bit phase, alphabet extremes, whitespace.
      send_flush();
      send_char("A");
      send_flush();
      send_char("/");
      send_char(BLANKS[0]);
      send_flush();
      send_char("+");
      send_char(BLANKS[1]);
      send_flush();
      send_char("z");
      send_char(BLANKS[2]);
      send_char("0");
      send_char("9");
      send_char(BLANKS[3]);
      send_char("Z");
      send_char("a");
      send_char(BLANKS[4]);
      send_char("/");
      send_char("/");
      send_char(BLANKS[5]);
      send_char("/");
      send_char("/");
      send_flush();

      // Random well-formed body: mostly symbols, some whitespace and flushes.
      for (int i = 0; i < BODY_BEATS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) send_char(symbol_char($urandom_range(0, 63)));
         else if (pick < 92) send_char(BLANKS[$urandom_range(0, 5)]);
         else send_flush();
      end

      // Padding ends the data; more padding, whitespace and flush stay quiet.
      send_char(symbol_char($urandom_range(0, 63)));
      send_char(symbol_char($urandom_range(0, 63)));
      send_char("=");
      send_char(BLANKS[$urandom_range(0, 5)]);
      send_char("=");
      send_flush();

      // One sticky error: either an invalid character or a symbol after padding.
      if ($urandom_range(0, 1) == 0) begin
         do begin
            ch = 8'($urandom);
            decode_scoreboard::classify_char(ch, kind, sym);
         end while (kind != KIND_BAD);
         send_char(ch);
      end else begin
         send_char(symbol_char($urandom_range(0, 63)));
      end

      // Error state: every beat answers the same way, any character or flush.
      send_char(8'h00);
      send_char(8'hFF);
      for (int i = 0; i < TAIL_BEATS; i++) begin
         if ($urandom_range(0, 3) == 0) send_flush();
         else send_char(8'($urandom));
      end
      push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.pending() != 0) $error("%0d predicted results never arrived", sb.pending());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("base64_stream_decoder test passed");
      end else begin
         $display("base64_stream_decoder test failed");
      end
      $finish;
   end

   // Result side: random pop gaps and one long hold-off so the input backs up.
   initial begin
      int gap;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == HOLD_AT) gap = HOLD_LEN;
         else gap = draw_gap(rx_calm);
         if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         sb.check_beat(rsp_data);
         taken++;
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("base64_stream_decoder test failed");
      $finish;
   end

endmodule
